/* design/round_robin_task_scheduler_defines.svh */
// Assertion helpers for the scheduler. Clock and reset names are those of the top level.
`ifndef ROUND_ROBIN_TASK_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RRTS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rrts: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define RRTS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rrts: next-cycle check failed");

`endif

/* design/rrts_pkg.sv */
package rrts_pkg;

    localparam int MODE_W  = 3;
    localparam int SLOT_FW = 4;
    localparam int TICK_W  = 16;
    localparam int LIVE_W  = 5;
    localparam int TIMER_W = 2 * TICK_W;

    localparam logic [MODE_W-1:0] MODE_TICK   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PICK   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CREATE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FREE   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_WAIT   = 3'd4;

    typedef struct packed {
        logic load;       // capture request, set up walk
        logic tick_step;  // issue one timer read of the tick walk
        logic scan_step;  // examine one slot for pick or create
        logic exec;       // single-cycle free / wait / no-op
        logic out_load;   // move the result into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic tick_none;  // no slot above zero to tick
        logic tick_last;  // current tick read is the last one
        logic scan_done;  // scan hit or ran through every slot
        logic out_free;   // output register can take a result
    } t_dp_sts;

endpackage

/* design/rrts_chan_if.sv */
interface rrts_req_if import rrts_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [SLOT_FW-1:0]  slot;
    logic [TICK_W-1:0]   delay_ticks;
    logic [TICK_W-1:0]   period_ticks;

    modport source (output valid, mode, slot, delay_ticks, period_ticks, input ready);
    modport sink   (input valid, mode, slot, delay_ticks, period_ticks, output ready);
endinterface

interface rrts_rsp_if import rrts_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SLOT_FW-1:0]  chosen_slot;
    logic                found;
    logic [LIVE_W-1:0]   live_count;

    modport source (output valid, chosen_slot, found, live_count, input ready);
    modport sink   (input valid, chosen_slot, found, live_count, output ready);
endinterface

/* design/rrts_ram.sv */
module rrts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/rrts_datapath.sv */
module rrts_datapath import rrts_pkg::*; #(
    parameter int NUM_SLOTS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_sts             o_sts,
    input  logic [MODE_W-1:0]   i_mode,
    input  logic [SLOT_FW-1:0]  i_slot,
    input  logic [TICK_W-1:0]   i_delay_ticks,
    input  logic [TICK_W-1:0]   i_period_ticks,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [SLOT_FW-1:0]  o_chosen_slot,
    output logic                o_found,
    output logic [LIVE_W-1:0]   o_live_count
);

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int HW_W   = $clog2(NUM_SLOTS + 1);

    // slot flags and bookkeeping
    logic [NUM_SLOTS-1:0] r_alive;
    logic [NUM_SLOTS-1:0] r_wait;
    logic [HW_W-1:0]      r_hw;
    logic [HW_W-1:0]      r_total;
    logic [SLOT_W-1:0]    r_rr;

    // request and walk
    logic [MODE_W-1:0]    r_mode;
    logic [SLOT_FW-1:0]   r_slot;
    logic [TICK_W-1:0]    r_delay;
    logic [TICK_W-1:0]    r_period;
    logic [SLOT_W-1:0]    r_idx;
    logic [SLOT_W-1:0]    r_cnt;
    logic                 r_wb_valid;
    logic [SLOT_W-1:0]    r_wb_idx;
    logic [SLOT_W-1:0]    r_chosen;
    logic                 r_found;

    // output register
    logic                 r_out_valid;
    logic [SLOT_FW-1:0]   r_out_chosen;
    logic                 r_out_found;
    logic [LIVE_W-1:0]    r_out_live;

    logic                 w_hit;
    logic                 w_cnt_last;
    logic [SLOT_W-1:0]    w_idx_next;
    logic                 w_slot_ok;
    logic [SLOT_W-1:0]    w_sidx;
    logic [TIMER_W-1:0]   w_rdata;
    logic [TICK_W-1:0]    w_cd;
    logic [TICK_W-1:0]    w_per;
    logic [TICK_W-1:0]    w_cd_new;
    logic                 w_wb_act;
    logic                 w_we;
    logic [SLOT_W-1:0]    w_waddr;
    logic [TIMER_W-1:0]   w_wdata;

    assign w_hit      = (r_mode == MODE_CREATE) ? !r_alive[r_idx]
                                                : (r_alive[r_idx] && !r_wait[r_idx]);
    assign w_cnt_last = (r_cnt == SLOT_W'(NUM_SLOTS - 1));
    assign w_idx_next = (r_idx == SLOT_W'(NUM_SLOTS - 1)) ? '0 : r_idx + SLOT_W'(1);
    assign w_slot_ok  = (int'(r_slot) < NUM_SLOTS);
    assign w_sidx     = SLOT_W'(r_slot);

    assign w_cd     = w_rdata[TICK_W-1:0];
    assign w_per    = w_rdata[TIMER_W-1:TICK_W];
    assign w_wb_act = r_alive[r_wb_idx] && r_wait[r_wb_idx];
    // expiry reloads the period; a zero period leaves the count at zero
    assign w_cd_new = (w_cd == '0) ? w_per : w_cd - TICK_W'(1);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = '0;
        priority if (r_wb_valid) begin
            w_we    = w_wb_act;
            w_waddr = r_wb_idx;
            w_wdata = {w_per, w_cd_new};
        end else if (i_cmd.scan_step && r_mode == MODE_CREATE && w_hit) begin
            w_we    = 1'b1;
            w_waddr = r_idx;
            w_wdata = '0;
        end else if (i_cmd.exec && r_mode == MODE_WAIT && w_slot_ok) begin
            w_we    = 1'b1;
            w_waddr = w_sidx;
            w_wdata = {r_period, r_delay};
        end else begin
            w_we    = 1'b0;
        end
    end

    rrts_ram #(
        .WIDTH (TIMER_W),
        .DEPTH (NUM_SLOTS)
    ) u_timer_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.tick_step),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive     <= '0;
            r_wait      <= '0;
            r_hw        <= '0;
            r_total     <= '0;
            r_rr        <= '0;
            r_wb_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_wb_valid <= i_cmd.tick_step;
            if (r_wb_valid && w_wb_act && w_cd == '0) begin
                r_wait[r_wb_idx] <= 1'b0;
            end
            if (i_cmd.scan_step && w_hit) begin
                if (r_mode == MODE_CREATE) begin
                    r_alive[r_idx] <= 1'b1;
                    r_wait[r_idx]  <= 1'b0;
                    if (HW_W'(r_idx) >= r_hw) begin
                        r_hw <= HW_W'(r_idx) + HW_W'(1);
                    end
                    r_total <= r_total + HW_W'(1);
                end else begin
                    r_rr <= w_idx_next;
                end
            end
            if (i_cmd.exec && w_slot_ok) begin
                if (r_mode == MODE_FREE && r_alive[w_sidx]) begin
                    r_alive[w_sidx] <= 1'b0;
                    // mark only steps down when the top slot goes
                    if (HW_W'(w_sidx) + HW_W'(1) == r_hw) begin
                        r_hw <= HW_W'(w_sidx);
                    end
                    if (r_total != '0) begin
                        r_total <= r_total - HW_W'(1);
                    end
                end
                if (r_mode == MODE_WAIT) begin
                    r_wait[w_sidx] <= 1'b1;
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode   <= i_mode;
            r_slot   <= i_slot;
            r_delay  <= i_delay_ticks;
            r_period <= i_period_ticks;
            r_cnt    <= '0;
            r_chosen <= '0;
            r_found  <= 1'b1;
            if (i_mode == MODE_PICK) begin
                r_idx <= r_rr;
            end else if (i_mode == MODE_TICK) begin
                r_idx <= SLOT_W'(1);  // slot zero is never ticked
            end else begin
                r_idx <= '0;
            end
        end
        if (i_cmd.tick_step) begin
            r_wb_idx <= r_idx;
            r_idx    <= w_idx_next;
        end
        if (i_cmd.scan_step) begin
            r_idx <= w_idx_next;
            r_cnt <= r_cnt + SLOT_W'(1);
            if (w_hit) begin
                r_chosen <= r_idx;
            end else if (w_cnt_last) begin
                r_found <= 1'b0;
            end
        end
        if (i_cmd.out_load) begin
            r_out_chosen <= SLOT_FW'(r_chosen);
            r_out_found  <= r_found;
            r_out_live   <= LIVE_W'(r_total);
        end
    end

    assign o_sts.tick_none = (r_hw <= HW_W'(1));
    assign o_sts.tick_last = (HW_W'(r_idx) + HW_W'(1) == r_hw);
    assign o_sts.scan_done = w_hit || w_cnt_last;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_chosen_slot = r_out_chosen;
    assign o_found       = r_out_found;
    assign o_live_count  = r_out_live;

endmodule

/* design/rrts_ctrl.sv */
module rrts_ctrl import rrts_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  logic [MODE_W-1:0] i_req_mode,
    output logic              o_req_ready,
    output t_dp_cmd           o_cmd,
    input  t_dp_sts           i_sts
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TICK  = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_EXEC  = 3'd4;
    localparam logic [2:0] S_RESP  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    unique case (i_req_mode)
                        MODE_TICK:   n_state = i_sts.tick_none ? S_RESP : S_TICK;
                        MODE_PICK,
                        MODE_CREATE: n_state = S_SCAN;
                        default:     n_state = S_EXEC;
                    endcase
                end
            end
            S_TICK: begin
                o_cmd.tick_step = 1'b1;
                if (i_sts.tick_last) begin
                    n_state = S_DRAIN;
                end
            end
            // last timer write-back happens here
            S_DRAIN: n_state = S_RESP;
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_RESP;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_RESP;
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* design/round_robin_task_scheduler.sv */
// Channel   Dir  Payload                                         Handshake
// i_req     in   mode, slot, delay_ticks, period_ticks           valid/ready
// o_rsp     out  chosen_slot, found, live_count                  valid/ready
//
// One request at a time. Tick walks slot timers from slot one to just below the high-water
// mark and then drains the last write-back; it skips the walk when the mark is at most one.
// Pick and create scan at most NUM_SLOTS slots; other modes pass through the exec step. The
// result sits in an output register, so a new request is taken while an earlier result is
// still waiting; the next result then waits for the output register to empty.
// Synchronous reset clears flags and counters at once; the timer RAM needs no clearing.
`include "round_robin_task_scheduler_defines.svh"

module round_robin_task_scheduler import rrts_pkg::*; #(
    parameter int NUM_SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rrts_req_if.sink    i_req,
    rrts_rsp_if.source  o_rsp
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    rrts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_mode  (i_req.mode),
        .o_req_ready (i_req.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    rrts_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_mode         (i_req.mode),
        .i_slot         (i_req.slot),
        .i_delay_ticks  (i_req.delay_ticks),
        .i_period_ticks (i_req.period_ticks),
        .i_out_ready    (o_rsp.ready),
        .o_out_valid    (o_rsp.valid),
        .o_chosen_slot  (o_rsp.chosen_slot),
        .o_found        (o_rsp.found),
        .o_live_count   (o_rsp.live_count)
    );

    `RRTS_ASSERT_IMP(a_one_cmd, 1'b1, $onehot0(w_cmd))
    `RRTS_ASSERT_IMP(a_load_when_free, w_cmd.out_load, w_sts.out_free)
    `RRTS_ASSERT_IMP(a_idle_no_result, i_req.ready, !w_cmd.out_load)
    `RRTS_ASSERT_NXT(a_busy_after_req, i_req.valid && i_req.ready, !i_req.ready)

endmodule
